[design/mbrm_pkg.sv]
// shared types, codes and the crc-16 byte step for the modbus rtu register master
// no dependencies
`default_nettype none

package mbrm_pkg;

  // stream payload widths
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;
  localparam int S_TUSER_W = 2;

  // input item kinds (s_tuser)
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_RESP  = 2'd2;

  // result kinds (m_tuser)
  localparam logic RES_TX     = 1'b0;
  localparam logic RES_REPORT = 1'b1;

  // outstanding transaction
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // modbus function codes and framing constants
  localparam logic [7:0]  FC_READ    = 8'h03;
  localparam logic [7:0]  FC_WRITE   = 8'h06;
  localparam logic [7:0]  EXC_FLAG   = 8'h80;
  localparam logic [15:0] READ_COUNT = 16'h0001;
  localparam logic [7:0]  READ_BYTES = 8'h02;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [7:0]  DEV_ADDR_RESET = 8'h01;

  // expected reply lengths
  localparam logic [3:0] LEN_EXC   = 4'd5;
  localparam logic [3:0] LEN_READ  = 4'd7;
  localparam logic [3:0] LEN_WRITE = 4'd8;
  localparam logic [3:0] LEN_MIN   = 4'd2;
  localparam logic [3:0] CNT_MAX   = 4'd15;

  // frame byte positions
  localparam logic [2:0] POS_CRC_LO = 3'd6;
  localparam logic [2:0] POS_CRC_HI = 3'd7;

  // completion status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_EXCEPTION = 3'd2;
  localparam logic [2:0] ST_EXC_LEN   = 3'd3;
  localparam logic [2:0] ST_BAD_FUNC  = 3'd4;
  localparam logic [2:0] ST_BAD_LEN   = 3'd5;
  localparam logic [2:0] ST_BAD_COUNT = 3'd6;
  localparam logic [2:0] ST_ECHO      = 3'd7;

  typedef struct packed {
    logic [3:0]  count;
    logic [7:0]  func;
    logic [7:0]  third;
    logic [15:0] data;
    logic        mismatch;
  } reply_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] read_value;
    logic [7:0]  exception_code;
  } report_t;

  // one byte through the reflected crc-16, eight bit steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[design/mbrm_reply_check.sv]
// reply byte bookkeeping and the completion checks of the register master
// depends on mbrm_pkg
`default_nettype none

module mbrm_reply_check
  import mbrm_pkg::*;
(
  input  wire logic [1:0] pending_op,
  input  wire reply_t     cur,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] sent_byte,
  output reply_t          nxt,
  output report_t         rpt
);

  logic [7:0] fcode;
  logic [7:0] exc_code;

  // fold the new byte into the reply state
  always_comb begin
    nxt = cur;
    case (cur.count)
      4'd1:    nxt.func = rx_byte;
      4'd2:    nxt.third = rx_byte;
      4'd3:    nxt.data = {rx_byte, cur.data[7:0]};
      4'd4:    nxt.data = {cur.data[15:8], rx_byte};
      default: ;
    endcase
    // bytes past the eighth never match the echo
    nxt.mismatch = cur.mismatch | cur.count[3] | (sent_byte != rx_byte);
    nxt.count = (cur.count == CNT_MAX) ? CNT_MAX : cur.count + 4'd1;
  end

  assign fcode    = (pending_op == OP_READ) ? FC_READ : FC_WRITE;
  assign exc_code = fcode | EXC_FLAG;

  // checks in priority order
  always_comb begin
    rpt = '0;
    if (nxt.count < LEN_MIN) begin
      rpt.status = ST_SHORT;
    end else if (nxt.func == exc_code) begin
      if (nxt.count != LEN_EXC) begin
        rpt.status = ST_EXC_LEN;
      end else begin
        rpt.status = ST_EXCEPTION;
        rpt.exception_code = nxt.third;
      end
    end else if (nxt.func != fcode) begin
      rpt.status = ST_BAD_FUNC;
    end else if (pending_op == OP_READ) begin
      if (nxt.count != LEN_READ) begin
        rpt.status = ST_BAD_LEN;
      end else if (nxt.third != READ_BYTES) begin
        rpt.status = ST_BAD_COUNT;
      end else begin
        rpt.status = ST_OK;
        rpt.read_value = nxt.data;
      end
    end else begin
      rpt.status = (nxt.mismatch || nxt.count != LEN_WRITE) ? ST_ECHO : ST_OK;
    end
  end

endmodule

`default_nettype wire

[design/modbus_rtu_register_master_unit.sv]
// modbus rtu master for one holding register: request framing, crc and reply checks
// depends on mbrm_pkg and mbrm_reply_check
`default_nettype none

// usage
//   slave side carries one item per beat: s_tuser is the kind (read request,
//   write request, reply byte), s_tdata the register address, write value and
//   reply byte, s_tlast marks the final reply byte of a frame
//   master side carries results: m_tuser 0 is a frame byte to transmit (m_tlast
//   on the eighth), m_tuser 1 is the completion report with status, read value
//   and exception code
//   a request gives eight frame beats; the first is loaded at the accept edge
//   and the frame sequencer adds one per cycle while the receiver keeps up, so
//   a request holds the slave side until the sequencer has loaded its last beat
//   a reply byte is taken at its accept edge; the final one loads the report into
//   the output register there, so m_tvalid is high from the next cycle
//   the crc is built byte by byte as the frame goes out, one byte step a cycle while the receiver keeps up
//   the output register parts the two sides: a new item is taken whenever no
//   frame is going out and the register is empty or being drained in the same cycle
//   a stalled receiver holds the output beat and with it the slave side
//   reset: device address 1, no request pending, reply state cleared;
//   reply bytes with no request pending are dropped
//   device address is written on cfg_wr_en; the user must write it only while the block is idle, not enforced here
module modbus_rtu_register_master_unit
  import mbrm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration
  input  wire logic                 cfg_wr_en,
  input  wire logic [7:0]           cfg_wr_data,    // device_address
  // slave side
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,        // reg_address, write_value, rx_byte
  input  wire logic [S_TUSER_W-1:0] s_tuser,        // kind
  input  wire logic                 s_tlast,        // rx_last
  // master side
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata,        // tx_byte, status, read_value,
                                                    // exception_code, zero fill
  output logic                      m_tuser,        // result_kind
  output logic                      m_tlast         // tx_last
);

  logic [7:0]  device_address;
  logic [1:0]  pending_op;
  logic [7:0]  sent_frame [8];
  logic [15:0] crc_reg;
  reply_t      reply;

  // frame sequencer
  logic        busy;
  logic [2:0]  seq_idx;

  logic        out_free;
  logic        accept;
  logic        req_accept;
  logic        rx_accept;
  logic        is_read;
  logic [15:0] in_addr;
  logic [15:0] in_value;
  logic [7:0]  in_rx_byte;
  logic [7:0]  req_func;
  logic [7:0]  req_b4;
  logic [7:0]  req_b5;
  logic [7:0]  emit_byte;
  logic        emit;
  reply_t      reply_next;
  report_t     report;

  assign in_addr    = s_tdata[15:0];
  assign in_value   = s_tdata[31:16];
  assign in_rx_byte = s_tdata[39:32];

  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = !busy && out_free;
  assign accept     = s_tvalid && s_tready;
  assign req_accept = accept && (s_tuser == KIND_READ || s_tuser == KIND_WRITE);
  assign rx_accept  = accept && (s_tuser == KIND_RESP) && (pending_op != OP_NONE);

  // request bytes known at the accept edge
  assign is_read  = (s_tuser == KIND_READ);
  assign req_func = is_read ? FC_READ : FC_WRITE;
  assign req_b4   = is_read ? READ_COUNT[15:8] : in_value[15:8];
  assign req_b5   = is_read ? READ_COUNT[7:0]  : in_value[7:0];

  // next frame byte out of the sequencer
  assign emit = busy && out_free;
  always_comb begin
    case (seq_idx)
      POS_CRC_LO: emit_byte = crc_reg[7:0];
      POS_CRC_HI: emit_byte = crc_reg[15:8];
      default:    emit_byte = sent_frame[seq_idx];
    endcase
  end

  mbrm_reply_check u_check (
    .pending_op (pending_op),
    .cur        (reply),
    .rx_byte    (in_rx_byte),
    .sent_byte  (sent_frame[reply.count[2:0]]),
    .nxt        (reply_next),
    .rpt        (report)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEV_ADDR_RESET;
      pending_op     <= OP_NONE;
      crc_reg        <= CRC_INIT;
      reply          <= '0;
      busy           <= 1'b0;
      seq_idx        <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        device_address <= cfg_wr_data;
      end
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (req_accept) begin
        // byte 0 goes straight to the output register
        pending_op <= is_read ? OP_READ : OP_WRITE;
        crc_reg    <= crc_byte(CRC_INIT, device_address);
        reply      <= '0;
        busy       <= 1'b1;
        seq_idx    <= 3'd1;
        m_tvalid   <= 1'b1;
      end else if (rx_accept) begin
        if (s_tlast) begin
          pending_op <= OP_NONE;
          reply      <= '0;
          m_tvalid   <= 1'b1;
        end else begin
          reply <= reply_next;
        end
      end else if (emit) begin
        if (seq_idx < POS_CRC_LO) begin
          crc_reg <= crc_byte(crc_reg, emit_byte);
        end
        if (seq_idx == POS_CRC_HI) begin
          busy <= 1'b0;
        end
        seq_idx  <= seq_idx + 3'd1;
        m_tvalid <= 1'b1;
      end
    end
  end

  // payload: frame copy and output beat
  always_ff @(posedge clk) begin
    if (req_accept) begin
      sent_frame[0] <= device_address;
      sent_frame[1] <= req_func;
      sent_frame[2] <= in_addr[15:8];
      sent_frame[3] <= in_addr[7:0];
      sent_frame[4] <= req_b4;
      sent_frame[5] <= req_b5;
      m_tuser       <= RES_TX;
      m_tlast       <= 1'b0;
      m_tdata       <= {{(M_TDATA_W-35){1'b0}}, 8'h00, 16'h0000, ST_OK, device_address};
    end else if (rx_accept && s_tlast) begin
      m_tuser <= RES_REPORT;
      m_tlast <= 1'b0;
      m_tdata <= {{(M_TDATA_W-35){1'b0}}, report.exception_code, report.read_value,
                  report.status, 8'h00};
    end else if (emit) begin
      // crc bytes join the frame copy for the write echo check
      if (seq_idx == POS_CRC_LO || seq_idx == POS_CRC_HI) begin
        sent_frame[seq_idx] <= emit_byte;
      end
      m_tuser <= RES_TX;
      m_tlast <= (seq_idx == POS_CRC_HI);
      m_tdata <= {{(M_TDATA_W-35){1'b0}}, 8'h00, 16'h0000, ST_OK, emit_byte};
    end
  end

  // a report only ever waits when no frame is going out
  a_report_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == RES_REPORT) |-> !busy)
    else $error("report beat while a frame is being sent");

  // a frame in flight always belongs to a pending request
  a_busy_pending: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pending_op != OP_NONE))
    else $error("frame sequencer running with no request pending");

  // the closing frame beat leaves the request pending and the sequencer stopped
  a_last_beat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == RES_TX && m_tlast) |-> (!busy && pending_op != OP_NONE))
    else $error("final frame beat out of step with the sequencer");

endmodule

`default_nettype wire
